// File: rtl/avn_pkg.sv
`timescale 1ns / 1ps
package avn_pkg;
   // Width of the result component and magnitude fields
   localparam int unsigned OUT_BITS = 16;
endpackage

// File: rtl/avn_sqrt_stage.sv
`timescale 1ns / 1ps
// One restoring square-root step: one root bit per stage
module avn_sqrt_stage #(
   parameter int unsigned SUM_BITS  = 34,
   parameter int unsigned ROOT_BITS = 17,
   parameter int unsigned STEP      = 0
) (
   input  logic [SUM_BITS-1:0]  rem_in,
   input  logic [ROOT_BITS-1:0] root_in,
   output logic [SUM_BITS-1:0]  rem_out,
   output logic [ROOT_BITS-1:0] root_out
);
   localparam int unsigned BITPOS = 2 * (ROOT_BITS - 1 - STEP);
   logic [SUM_BITS+1:0] trial;
   always_comb begin
      trial = ({2'b00, SUM_BITS'(root_in)} << (ROOT_BITS - STEP))
            | ((SUM_BITS + 2)'(1) << BITPOS);
      if ({2'b00, rem_in} >= trial) begin
         rem_out  = rem_in - trial[SUM_BITS-1:0];
         root_out = root_in | (ROOT_BITS'(1) << (ROOT_BITS - 1 - STEP));
      end else begin
         rem_out  = rem_in;
         root_out = root_in;
      end
   end
endmodule

// File: rtl/avn_div_stage.sv
`timescale 1ns / 1ps
// One restoring division step: one quotient bit
module avn_div_stage #(
   parameter int unsigned DIV_BITS = 17,
   parameter int unsigned Q_BITS   = 31,
   parameter int unsigned STEP     = 0
) (
   input  logic [DIV_BITS-1:0] div,
   input  logic [DIV_BITS:0]   rem_in,
   input  logic [Q_BITS-1:0]   num_in,
   input  logic [Q_BITS-1:0]   q_in,
   output logic [DIV_BITS:0]   rem_out,
   output logic [Q_BITS-1:0]   q_out
);
   logic [DIV_BITS+1:0] shifted;
   always_comb begin
      shifted = {rem_in, num_in[Q_BITS-1-STEP]};
      if (shifted >= {1'b0, 1'b0, div}) begin
         shifted = shifted - {2'b00, div};
         q_out   = q_in | (Q_BITS'(1) << (Q_BITS - 1 - STEP));
      end else begin
         q_out = q_in;
      end
      rem_out = shifted[DIV_BITS:0];
   end
endmodule

// File: rtl/accel_vector_normalizer.sv
`timescale 1ns / 1ps
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+--------------------------
// request   | start, busy, req_raw_x/y/z         | start && !busy
// result    | rsp_valid, rsp_unit_x/y/z,         | one-cycle strobe, no hold
//           | rsp_magnitude, rsp_zero_vector     |
// One request per cycle; busy is always low. The pipeline has
// 3 + ROOT_BITS + Q_BITS register stages: absolute values, squaring/sum, one
// square-root step per stage, one quotient bit per stage, then saturate. Reset
// clears the valid bits only; the result side cannot stall, so nothing waits.
module accel_vector_normalizer #(
   parameter int unsigned SAMPLE_BITS   = 16,
   parameter int unsigned FRACTION_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [SAMPLE_BITS-1:0] req_raw_x,
   input  logic [SAMPLE_BITS-1:0] req_raw_y,
   input  logic [SAMPLE_BITS-1:0] req_raw_z,
   output logic                   rsp_valid,
   output logic [15:0]            rsp_unit_x,
   output logic [15:0]            rsp_unit_y,
   output logic [15:0]            rsp_unit_z,
   output logic [15:0]            rsp_magnitude,
   output logic                   rsp_zero_vector
);
   localparam int unsigned SUM_BITS  = 2 * SAMPLE_BITS + 2;
   localparam int unsigned ROOT_BITS = SAMPLE_BITS + 1;
   localparam int unsigned Q_BITS    = SAMPLE_BITS + FRACTION_BITS;
   localparam int unsigned OB        = avn_pkg::OUT_BITS;

   assign busy = 1'b0;

   // Stage 0: absolute values and signs
   logic                   v0_ff;
   logic [SAMPLE_BITS-1:0] a0_ff [3];
   logic [2:0]             s0_ff;
   logic [SAMPLE_BITS-1:0] raw_in [3];
   assign raw_in[0] = req_raw_x;
   assign raw_in[1] = req_raw_y;
   assign raw_in[2] = req_raw_z;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else       v0_ff <= start;
      for (int i = 0; i < 3; i++) begin
         s0_ff[i] <= raw_in[i][SAMPLE_BITS-1];
         a0_ff[i] <= raw_in[i][SAMPLE_BITS-1] ? SAMPLE_BITS'(-raw_in[i]) : raw_in[i];
      end
   end

   // Stage 1: sum of squares
   logic                   v1_ff;
   logic [SUM_BITS-1:0]    sum1_ff;
   logic [SAMPLE_BITS-1:0] a1_ff [3];
   logic [2:0]             s1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v0_ff;
      sum1_ff <= SUM_BITS'(a0_ff[0] * a0_ff[0]) + SUM_BITS'(a0_ff[1] * a0_ff[1])
               + SUM_BITS'(a0_ff[2] * a0_ff[2]);
      a1_ff <= a0_ff;
      s1_ff <= s0_ff;
   end

   // Square-root pipeline, one root bit per stage
   logic                   sv_ff   [ROOT_BITS+1];
   logic [SUM_BITS-1:0]    srem_ff [ROOT_BITS+1];
   logic [ROOT_BITS-1:0]   sroot_ff[ROOT_BITS+1];
   logic [SAMPLE_BITS-1:0] sa_ff   [ROOT_BITS+1][3];
   logic [2:0]             ss_ff   [ROOT_BITS+1];
   always_comb begin
      sv_ff[0] = v1_ff;
      srem_ff[0] = sum1_ff;
      sroot_ff[0] = '0;
      sa_ff[0] = a1_ff;
      ss_ff[0] = s1_ff;
   end
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
      logic [SUM_BITS-1:0]  rem_in;
      logic [ROOT_BITS-1:0] root_in;
      avn_sqrt_stage #(.SUM_BITS(SUM_BITS), .ROOT_BITS(ROOT_BITS), .STEP(k)) u_st (
         .rem_in(srem_ff[k]), .root_in(sroot_ff[k]), .rem_out(rem_in), .root_out(root_in)
      );
      always_ff @(posedge clock) begin
         if (reset) sv_ff[k+1] <= 1'b0;
         else       sv_ff[k+1] <= sv_ff[k];
         srem_ff[k+1]  <= rem_in;
         sroot_ff[k+1] <= root_in;
         sa_ff[k+1]    <= sa_ff[k];
         ss_ff[k+1]    <= ss_ff[k];
      end
   end

   // Divisor: forced to one for a zero vector
   logic [ROOT_BITS-1:0] mag;
   logic                 zero;
   assign mag  = sroot_ff[ROOT_BITS];
   assign zero = (mag == '0);

   // Division pipeline, one quotient bit per stage for all three lanes
   logic                 dv_ff  [Q_BITS+1];
   logic [ROOT_BITS-1:0] dd_ff  [Q_BITS+1];
   logic [ROOT_BITS:0]   dr_ff  [Q_BITS+1][3];
   logic [Q_BITS-1:0]    dn_ff  [Q_BITS+1][3];
   logic [Q_BITS-1:0]    dq_ff  [Q_BITS+1][3];
   logic [2:0]           ds_ff  [Q_BITS+1];
   logic [ROOT_BITS-1:0] dm_ff  [Q_BITS+1];
   logic                 dz_ff  [Q_BITS+1];
   always_comb begin
      dv_ff[0] = sv_ff[ROOT_BITS];
      dd_ff[0] = zero ? ROOT_BITS'(1) : mag;
      ds_ff[0] = ss_ff[ROOT_BITS];
      dm_ff[0] = mag;
      dz_ff[0] = zero;
      for (int i = 0; i < 3; i++) begin
         dr_ff[0][i] = '0;
         dq_ff[0][i] = '0;
         dn_ff[0][i] = {sa_ff[ROOT_BITS][i], FRACTION_BITS'(0)};
      end
   end
   for (genvar k = 0; k < Q_BITS; k++) begin : g_div
      logic [ROOT_BITS:0]  r_nx [3];
      logic [Q_BITS-1:0]   q_nx [3];
      for (genvar i = 0; i < 3; i++) begin : g_lane
         avn_div_stage #(.DIV_BITS(ROOT_BITS), .Q_BITS(Q_BITS), .STEP(k)) u_dv (
            .div(dd_ff[k]), .rem_in(dr_ff[k][i]), .num_in(dn_ff[k][i]),
            .q_in(dq_ff[k][i]), .rem_out(r_nx[i]), .q_out(q_nx[i])
         );
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else       dv_ff[k+1] <= dv_ff[k];
         dd_ff[k+1] <= dd_ff[k];
         dr_ff[k+1] <= r_nx;
         dq_ff[k+1] <= q_nx;
         dn_ff[k+1] <= dn_ff[k];
         ds_ff[k+1] <= ds_ff[k];
         dm_ff[k+1] <= dm_ff[k];
         dz_ff[k+1] <= dz_ff[k];
      end
   end

   // Output stage: saturate to one, restore sign
   localparam logic [Q_BITS-1:0] ONE = Q_BITS'(1) << FRACTION_BITS;
   logic          ov_ff;
   logic [OB-1:0] ou_ff [3];
   logic [OB-1:0] om_ff;
   logic          oz_ff;
   logic [Q_BITS-1:0] sat [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat[i] = (dq_ff[Q_BITS][i] > ONE) ? ONE : dq_ff[Q_BITS][i];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= dv_ff[Q_BITS];
      for (int i = 0; i < 3; i++) begin
         ou_ff[i] <= ds_ff[Q_BITS][i] ? OB'(-sat[i]) : OB'(sat[i]);
      end
      om_ff <= OB'(dm_ff[Q_BITS]);
      oz_ff <= dz_ff[Q_BITS];
   end

   assign rsp_valid       = ov_ff;
   assign rsp_unit_x      = ou_ff[0];
   assign rsp_unit_y      = ou_ff[1];
   assign rsp_unit_z      = ou_ff[2];
   assign rsp_magnitude   = om_ff;
   assign rsp_zero_vector = oz_ff;

   // A zero vector reports zero magnitude and zero components
   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_magnitude == '0 && rsp_unit_x == '0)
      else $error("zero vector with nonzero outputs");
   // A valid leaving the sum-of-squares stage reaches the first square-root register
   a_v_track: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> sv_ff[1])
      else $error("valid lost in square-root pipe");
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_magnitude != '0 |-> !rsp_zero_vector)
      else $error("zero flag with nonzero magnitude");
endmodule

// File: test/accel_vector_normalizer_tb.sv
`timescale 1ns / 1ps
module accel_vector_normalizer_tb;
   localparam int unsigned SAMPLE_BITS   = 16;
   localparam int unsigned FRACTION_BITS = 14;
   localparam int unsigned ROOT_BITS     = SAMPLE_BITS + 1;
   localparam int unsigned Q_BITS        = SAMPLE_BITS + FRACTION_BITS;
   localparam int unsigned PIPE_DEPTH    = 3 + ROOT_BITS + Q_BITS;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } sample_type;

   typedef struct packed {
      logic [avn_pkg::OUT_BITS-1:0] ux;
      logic [avn_pkg::OUT_BITS-1:0] uy;
      logic [avn_pkg::OUT_BITS-1:0] uz;
      logic [avn_pkg::OUT_BITS-1:0] mag;
      logic                         zero;
   } unit_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [SAMPLE_BITS-1:0] req_raw_x = '0;
   logic [SAMPLE_BITS-1:0] req_raw_y = '0;
   logic [SAMPLE_BITS-1:0] req_raw_z = '0;
   logic rsp_valid;
   logic [15:0] rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_magnitude;
   logic rsp_zero_vector;

   sample_type   pending_samples[$];
   unit_vec_type expected_units[$];
   int unsigned errors = 0;
   int unsigned cycle_count = 0;
   int unsigned accepted = 0;
   int unsigned total_samples = 0;
   bit stimulus_done = 1'b0;

   accel_vector_normalizer #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_x(req_raw_x), .req_raw_y(req_raw_y), .req_raw_z(req_raw_z),
      .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_unit_z(rsp_unit_z), .rsp_magnitude(rsp_magnitude),
      .rsp_zero_vector(rsp_zero_vector)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Floor square root, bit by bit
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [15:0] scale_axis(logic signed [15:0] c, longint unsigned div);
      longint unsigned a;
      longint unsigned q;
      a = (c < 0) ? longint'(-int'(c)) : longint'(int'(c));
      q = (a << FRACTION_BITS) / div;
      if (q > (64'd1 << FRACTION_BITS)) q = 64'd1 << FRACTION_BITS;
      if (c < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic unit_vec_type normalize(sample_type s);
      unit_vec_type r;
      longint signed sx, sy, sz;
      longint unsigned sum, mag, div;
      sx = $signed(s.x);
      sy = $signed(s.y);
      sz = $signed(s.z);
      sum = sx * sx + sy * sy + sz * sz;
      mag = floor_sqrt(sum);
      div = (mag == 0) ? 1 : mag;
      r.ux = scale_axis(s.x, div);
      r.uy = scale_axis(s.y, div);
      r.uz = scale_axis(s.z, div);
      r.mag = mag[15:0];
      r.zero = (mag == 0);
      return r;
   endfunction

   function automatic logic [15:0] pick_axis();
      int unsigned k;
      k = $urandom_range(0, 9);
      case (k)
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // Build the request list: corners first, then random samples
   initial begin
      sample_type s;
      logic [15:0] corners[5];
      corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
      for (int i = 0; i < 5; i++) begin
         s.x = corners[i]; s.y = corners[(i + 1) % 5]; s.z = corners[(i + 3) % 5];
         pending_samples.push_back(s);
      end
      // all-zero vector, full-scale diagonals and single axes, floor-overshoot cases and a mixed pattern
      pending_samples.push_back(sample_type'{16'h0000, 16'h0000, 16'h0000});
      pending_samples.push_back(sample_type'{16'h8000, 16'h8000, 16'h8000});
      pending_samples.push_back(sample_type'{16'h7FFF, 16'h7FFF, 16'h7FFF});
      pending_samples.push_back(sample_type'{16'h8000, 16'h0000, 16'h0000});
      pending_samples.push_back(sample_type'{16'h0000, 16'h7FFF, 16'h0000});
      pending_samples.push_back(sample_type'{16'h0000, 16'h0000, 16'hFFFF});
      pending_samples.push_back(sample_type'{16'h0003, 16'h0001, 16'h0001});
      pending_samples.push_back(sample_type'{16'hFFFD, 16'hFFFF, 16'h0001});
      pending_samples.push_back(sample_type'{16'h0001, 16'h0001, 16'h0000});
      pending_samples.push_back(sample_type'{16'h5555, 16'hAAAA, 16'h0F0F});
      for (int i = 0; i < 1450; i++) begin
         s.x = pick_axis(); s.y = pick_axis(); s.z = pick_axis();
         pending_samples.push_back(s);
      end
      total_samples = pending_samples.size();
   end

   task automatic s_drive(sample_type s);
      start     <= 1'b1;
      req_raw_x <= s.x;
      req_raw_y <= s.y;
      req_raw_z <= s.z;
   endtask

   // Driver: offer one request per cycle while busy is low, idle at random except while accepted is 401 to 699
   always @(posedge clock) begin
      bit idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_units.push_back(normalize(sample_type'{req_raw_x, req_raw_y, req_raw_z}));
            accepted++;
         end
         if (start && busy) begin
            // hold the current request
         end else begin
            idle = (accepted > 400 && accepted < 700) ? 1'b0 : ($urandom_range(0, 99) < 35);
            if (pending_samples.size() != 0 && !idle) begin
               s_drive(pending_samples.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      unit_vec_type e;
      if (!reset && rsp_valid) begin
         if (expected_units.size() == 0) begin
            $error("unexpected result with nothing pending");
            errors++;
         end else begin
            e = expected_units.pop_front();
            if (rsp_unit_x !== e.ux) begin
               $error("unit_x expected %0d actual %0d", $signed(e.ux), $signed(rsp_unit_x));
               errors++;
            end
            if (rsp_unit_y !== e.uy) begin
               $error("unit_y expected %0d actual %0d", $signed(e.uy), $signed(rsp_unit_y));
               errors++;
            end
            if (rsp_unit_z !== e.uz) begin
               $error("unit_z expected %0d actual %0d", $signed(e.uz), $signed(rsp_unit_z));
               errors++;
            end
            if (rsp_magnitude !== e.mag) begin
               $error("magnitude expected %0d actual %0d", e.mag, rsp_magnitude);
               errors++;
            end
            if (rsp_zero_vector !== e.zero) begin
               $error("zero_vector expected %0d actual %0d", e.zero, rsp_zero_vector);
               errors++;
            end
         end
      end
   end

   // Run control: reset, drain, settle, report
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (total_samples != 0 && accepted == total_samples);
      wait (expected_units.size() == 0);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      stimulus_done = 1'b1;
      if (errors == 0 && expected_units.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT && !stimulus_done) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end
endmodule

// File: sim.f
rtl/avn_pkg.sv
rtl/avn_sqrt_stage.sv
rtl/avn_div_stage.sv
rtl/accel_vector_normalizer.sv
test/accel_vector_normalizer_tb.sv
